@@ rtl/smart_case_substring_search_unit_assert.svh @@
// Assertion macros used by the checker file of the substring search unit.
`ifndef SMART_CASE_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define SMART_CASE_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSCS_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("sscs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSCS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("sscs assertion failed");

`endif

@@ rtl/sscs_pkg.sv @@
// Types, codes and byte compare helpers of the smart-case substring search unit.
package sscs_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEXT   = 2'd2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_MODE     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_ORDER = 1'b1;

  localparam logic [7:0] CHAR_CAP_A = 8'h41;
  localparam logic [7:0] CHAR_CAP_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
    logic [31:0] match_end;
    logic        pattern_overflow;
  } out_item_t;

  typedef struct packed {
    logic exact;
    logic reverse;
  } cmp_ctrl_t;

  function automatic logic is_capital(input logic [7:0] c);
    return (c >= CHAR_CAP_A) && (c <= CHAR_CAP_Z);
  endfunction

  function automatic logic [7:0] to_small(input logic [7:0] c);
    return is_capital(c) ? (c + CASE_DELTA) : c;
  endfunction

  function automatic logic byte_eq(input logic [7:0] t, input logic [7:0] p,
                                   input logic exact);
    return (t == p) || (!exact && (to_small(t) == to_small(p)));
  endfunction

endpackage

@@ rtl/smart_case_substring_search_unit.sv @@
// Top level of the smart-case substring search unit.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_ready  | in_data (cmd, data_byte)
//   out_       | output    | out_valid/out_ready| out_data (match and overflow)
//   cfg_       | input     | cfg_we             | cfg_index, cfg_wdata
//
// One item is taken every cycle unless the output stalls; its result is registered.
// The window compare against all pattern bytes sits between the input register
// and the result register, so throughput is set by that single stage.
// Reset clears the pattern length, fill count, position, flags and valid bits.
// A stalled output holds its result while the input register still takes one item.
module smart_case_substring_search_unit #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sscs_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sscs_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [sscs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sscs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int EW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  logic                     fold_r;
  logic                     rev_r;
  logic                     in_vld_r;
  sscs_pkg::in_item_t       in_item_r;
  logic                     out_vld_r;
  sscs_pkg::out_item_t      out_item_r;
  logic [7:0]               pat_fwd_r [PATTERN_MAX];
  logic [7:0]               pat_rev_r [PATTERN_MAX];
  logic [7:0]               win_r     [PATTERN_MAX];
  logic [LW-1:0]            len_r;
  logic [LW-1:0]            fill_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     has_cap_r;
  logic                     found_r;

  logic                     advance;
  logic                     fire;
  logic [7:0]               taps [PATTERN_MAX];
  logic                     len_full;
  logic [LW-1:0]            fill_nxt;
  logic [POSITION_BITS-1:0] pos_end;
  logic [POSITION_BITS-1:0] pos_start;
  logic [EW-1:0]            end_ext;
  logic [EW-1:0]            start_ext;
  sscs_pkg::cmp_ctrl_t      ctrl;
  logic                     all_eq;
  logic                     text_hit;
  sscs_pkg::out_item_t      res_nxt;

  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  always_comb begin
    taps[0] = in_item_r.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      taps[k] = win_r[k-1];
    end
  end

  assign len_full  = (len_r == LW'(PATTERN_MAX));
  assign fill_nxt  = (fill_r == LW'(PATTERN_MAX)) ? fill_r : (fill_r + 1'b1);
  assign pos_end   = pos_r + 1'b1;
  assign pos_start = pos_end - POSITION_BITS'(len_r);
  assign end_ext   = EW'(pos_end);
  assign start_ext = EW'(pos_start);

  assign ctrl.exact   = !fold_r && has_cap_r;
  assign ctrl.reverse = rev_r;

  sscs_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .LW          (LW)
  ) u_match (
    .taps    (taps),
    .pat_fwd (pat_fwd_r),
    .pat_rev (pat_rev_r),
    .len     (len_r),
    .ctrl    (ctrl),
    .hit     (all_eq)
  );

  assign text_hit = (len_r != '0) && !found_r && (fill_nxt >= len_r) && all_eq;

  always_comb begin
    res_nxt = '0;
    unique case (in_item_r.cmd)
      sscs_pkg::CMD_APPEND: begin
        res_nxt.pattern_overflow = len_full;
      end
      sscs_pkg::CMD_TEXT: begin
        if (text_hit) begin
          res_nxt.match_found = 1'b1;
          res_nxt.match_start = start_ext[31:0];
          res_nxt.match_end   = end_ext[31:0];
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r    <= 1'b0;
      rev_r     <= 1'b0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      len_r     <= '0;
      fill_r    <= '0;
      pos_r     <= '0;
      has_cap_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sscs_pkg::REG_FOLD_MODE) begin
          fold_r <= cfg_wdata[0];
        end
        if (cfg_index == sscs_pkg::REG_REVERSE_ORDER) begin
          rev_r <= cfg_wdata[0];
        end
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (fire) begin
        unique case (in_item_r.cmd)
          sscs_pkg::CMD_CLEAR: begin
            len_r     <= '0;
            fill_r    <= '0;
            pos_r     <= '0;
            has_cap_r <= 1'b0;
            found_r   <= 1'b0;
          end
          sscs_pkg::CMD_APPEND: begin
            if (!len_full) begin
              len_r <= len_r + 1'b1;
              if (sscs_pkg::is_capital(in_item_r.data_byte)) begin
                has_cap_r <= 1'b1;
              end
            end
          end
          sscs_pkg::CMD_TEXT: begin
            fill_r <= fill_nxt;
            pos_r  <= pos_end;
            if (text_hit) begin
              found_r <= 1'b1;
            end
          end
          default: begin
            found_r <= found_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (fire) begin
      out_item_r <= res_nxt;
      if ((in_item_r.cmd == sscs_pkg::CMD_APPEND) && !len_full) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
          if (LW'(j) == len_r) begin
            pat_fwd_r[j] <= in_item_r.data_byte;
          end
        end
        pat_rev_r[0] <= in_item_r.data_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
          pat_rev_r[j] <= pat_rev_r[j-1];
        end
      end
      if (in_item_r.cmd == sscs_pkg::CMD_TEXT) begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
          win_r[j] <= taps[j];
        end
      end
    end
  end

endmodule

@@ rtl/sscs_match.sv @@
// Parallel compare of the text window against every pattern byte.
module sscs_match #(
  parameter int PATTERN_MAX = 64,
  parameter int LW          = 7
) (
  input  logic [7:0]           taps    [PATTERN_MAX],
  input  logic [7:0]           pat_fwd [PATTERN_MAX],
  input  logic [7:0]           pat_rev [PATTERN_MAX],
  input  logic [LW-1:0]        len,
  input  sscs_pkg::cmp_ctrl_t  ctrl,
  output logic                 hit
);

  logic [PATTERN_MAX-1:0] eq;

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      eq[k] = (LW'(k) >= len) ||
              sscs_pkg::byte_eq(taps[k], ctrl.reverse ? pat_fwd[k] : pat_rev[k],
                                ctrl.exact);
    end
  end

  assign hit = &eq;

endmodule

@@ rtl/sscs_checker.sv @@
// Port-level checker of the substring search unit and its bind statement.
`include "smart_case_substring_search_unit_assert.svh"

module sscs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sscs_pkg::out_item_t out_data
);

  logic no_pos;

  assign no_pos = (out_data.match_start == 32'd0) && (out_data.match_end == 32'd0);

  `SSCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `SSCS_ASSERT_NOW(a_in_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `SSCS_ASSERT_NOW(a_no_match_zero_pos, clk, rst_n, out_valid && !out_data.match_found, no_pos)
  `SSCS_ASSERT_NOW(a_overflow_no_match, clk, rst_n, out_valid && out_data.pattern_overflow, !out_data.match_found)

endmodule

bind smart_case_substring_search_unit sscs_checker u_sscs_checker (.*);
